// File: rtl/lri_pkg.sv
// ----------------------------------------------------------------------------
// lri_pkg
// Shared types, codes and arithmetic helpers of the logistic regression block.
// ----------------------------------------------------------------------------
package lri_pkg;

   localparam int DATA_WIDTH        = 16;
   localparam int FRAC_BITS         = 12;
   localparam int ACC_WIDTH         = 40;
   localparam int LRI_MAX_FEATURES  = 64;
   localparam int LRI_MAX_CLASSES   = 16;

   localparam logic [1:0] KIND_WEIGHT  = 2'd0;
   localparam logic [1:0] KIND_BIAS    = 2'd1;
   localparam logic [1:0] KIND_FEATURE = 2'd2;

   localparam logic [0:0] CSR_FEATURE_COUNT = 1'd0;
   localparam logic [0:0] CSR_CLASS_COUNT   = 1'd1;

   typedef struct packed {
      logic [1:0]                   kind;
      logic [5:0]                   feature_index;
      logic [3:0]                   class_index;
      logic signed [DATA_WIDTH-1:0] value;
   } lri_req_type;

   typedef struct packed {
      logic [3:0]  out_class;
      logic [15:0] probability;
      logic        last;
   } lri_rsp_type;

   function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
      input logic signed [ACC_WIDTH:0] v);
      logic signed [ACC_WIDTH-1:0] r;
      if (v[ACC_WIDTH] != v[ACC_WIDTH-1]) begin
         r = v[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
         r = v[ACC_WIDTH-1:0];
      end
      return r;
   endfunction

   // round(exp(-2^(b-12)) * 2^32)
   function automatic logic [31:0] exp_bit(input logic [3:0] b);
      logic [31:0] t;
      unique case (b)
         4'd0:    t = 32'd4293918848;
         4'd1:    t = 32'd4292870656;
         4'd2:    t = 32'd4290775039;
         4'd3:    t = 32'd4286586875;
         4'd4:    t = 32'd4278222805;
         4'd5:    t = 32'd4261543595;
         4'd6:    t = 32'd4228380000;
         4'd7:    t = 32'd4162825044;
         4'd8:    t = 32'd4034748382;
         4'd9:    t = 32'd3790295335;
         4'd10:   t = 32'd3344923893;
         4'd11:   t = 32'd2605029347;
         4'd12:   t = 32'd1580030169;
         4'd13:   t = 32'd581260615;
         4'd14:   t = 32'd78665070;
         4'd15:   t = 32'd1440801;
         default: t = 32'd0;
      endcase
      return t;
   endfunction

endpackage

// File: rtl/lri_ram.sv
// ----------------------------------------------------------------------------
// lri_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lri_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/logistic_regression_inference.sv
// ----------------------------------------------------------------------------
// logistic_regression_inference
// Fixed-point multinomial logistic regression inference, memory based.
// ----------------------------------------------------------------------------
// Usage: each req transaction carries a kind. Weight and bias transactions
// write the weight RAM (row feature_index, column class_index) or the bias
// RAM and are taken back to back. Feature transactions arrive in sample
// order; each one runs a multiply-accumulate sweep over the classes through
// one shared multiplier and the accumulator RAM, read through its single
// read port and written back through its write port: req_stall is high for
// the whole sweep, so the next feature is taken only once it is done.
// On the last feature of a sample the block forms the logits, then the
// exponential, once for sigmoid and per class for softmax (one table
// multiply per cycle), then per class a restoring division with its read
// (softmax only), load and output states.
// Sigmoid is used for one class, softmax otherwise; each rsp
// transaction gives one class probability, last set on the final one.
// rsp is held in an output register; a stalled rsp holds the block in its
// output state, delaying the remaining classes and the next req transaction.
// csr writes take effect at once and are meant for idle periods.
// Reset (synchronous) clears accumulators, position and sets both counts to 1.
// ----------------------------------------------------------------------------
module logistic_regression_inference
   import lri_pkg::*;
#(
   parameter int MAX_FEATURES = LRI_MAX_FEATURES,
   parameter int MAX_CLASSES  = LRI_MAX_CLASSES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lri_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lri_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int RW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CIW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int WDEPTH = MAX_FEATURES * MAX_CLASSES;
   localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int SW  = 34 + ((MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 0);
   localparam int NW  = SW + 17;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MAC   = 10'b0000000010,
      S_LOGIT = 10'b0000000100,
      S_EXPRD = 10'b0000001000,
      S_EXPLD = 10'b0000010000,
      S_EXP   = 10'b0000100000,
      S_DIVRD = 10'b0001000000,
      S_DIVLD = 10'b0010000000,
      S_DIV   = 10'b0100000000,
      S_EMIT  = 10'b1000000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [6:0]                  pos_ff, pos_in;
   logic [6:0]                  fcount_ff, fcount_in;
   logic [4:0]                  ccount_ff, ccount_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic                        p1_v_ff, p1_v_in, p2_v_ff, p2_v_in;
   logic [4:0]                  p1_c_ff, p1_c_in, p2_c_ff, p2_c_in;
   logic signed [DATA_WIDTH-1:0] x_ff, x_in;
   logic [RW-1:0]               row_ff, row_in;
   logic signed [31:0]          prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0] accd_ff, accd_in;
   logic [MAX_CLASSES-1:0]      vld_ff, vld_in;
   logic signed [ACC_WIDTH-1:0] zmax_ff, zmax_in;
   logic                        zneg_ff, zneg_in;
   logic [32:0]                 r_ff, r_in;
   logic [15:0]                 q_ff, q_in;
   logic [4:0]                  step_ff, step_in;
   logic [SW-1:0]               sum_ff, sum_in;
   logic [SW-1:0]               den_ff, den_in;
   logic [SW-1:0]               rem_ff, rem_in;
   logic [16:0]                 nlow_ff, nlow_in;
   logic [16:0]                 quo_ff, quo_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   lri_rsp_type                 rsp_data_ff, rsp_data_in;

   logic                        w_we, b_we, a_we;
   logic [WAW-1:0]              w_waddr, w_raddr;
   logic [CIW-1:0]              b_waddr, a_waddr, cidx;
   logic [ACC_WIDTH-1:0]        a_wdata;
   logic [DATA_WIDTH-1:0]       w_rdata, b_rdata;
   logic [ACC_WIDTH-1:0]        a_rdata;
   logic [6:0]                  nf;
   logic [4:0]                  nc;

   lri_ram #(.WIDTH(DATA_WIDTH), .DEPTH(WDEPTH)) u_weight_ram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(req_data.value),
      .rd_addr(w_raddr), .rd_data(w_rdata)
   );

   lri_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_CLASSES)) u_bias_ram (
      .clock(clock), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(req_data.value),
      .rd_addr(cidx), .rd_data(b_rdata)
   );

   lri_ram #(.WIDTH(ACC_WIDTH), .DEPTH(MAX_CLASSES)) u_acc_ram (
      .clock(clock), .wr_en(a_we), .wr_addr(a_waddr), .wr_data(a_wdata),
      .rd_addr(cidx), .rd_data(a_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign nf = (fcount_ff == 7'd0) ? 7'd1 :
               ((int'(fcount_ff) > MAX_FEATURES) ? 7'(MAX_FEATURES) : fcount_ff);
   assign nc = (ccount_ff == 5'd0) ? 5'd1 :
               ((int'(ccount_ff) > MAX_CLASSES) ? 5'(MAX_CLASSES) : ccount_ff);

   assign cidx    = CIW'(cnt_ff);
   assign w_raddr = WAW'(int'(row_ff) * MAX_CLASSES + int'(cnt_ff));
   assign w_waddr = WAW'(int'(req_data.feature_index) * MAX_CLASSES +
                         int'(req_data.class_index));
   assign b_waddr = CIW'(req_data.class_index);

   always_comb begin
      logic                        accept;
      logic [6:0]                  pos_next;
      logic signed [ACC_WIDTH:0]   mac_sum;
      logic signed [ACC_WIDTH:0]   logit;
      logic signed [ACC_WIDTH-1:0] acc_val;
      logic signed [ACC_WIDTH-1:0] z;
      logic signed [ACC_WIDTH:0]   m;
      logic [64:0]                 emul;
      logic [32:0]                 r_next;
      logic [32:0]                 e;
      logic [48:0]                 num;
      logic [SW-1:0]               den;
      logic [NW-1:0]               nsum;
      logic [SW:0]                 trial;
      logic                        sig;
      logic                        last;

      state_in     = state_ff;
      pos_in       = pos_ff;
      fcount_in    = fcount_ff;
      ccount_in    = ccount_ff;
      cnt_in       = cnt_ff;
      p1_v_in      = 1'b0;
      p1_c_in      = p1_c_ff;
      p2_v_in      = 1'b0;
      p2_c_in      = p2_c_ff;
      x_in         = x_ff;
      row_in       = row_ff;
      prod_in      = prod_ff;
      accd_in      = accd_ff;
      vld_in       = vld_ff;
      zmax_in      = zmax_ff;
      zneg_in      = zneg_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      nlow_in      = nlow_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      w_we         = 1'b0;
      b_we         = 1'b0;
      a_we         = 1'b0;
      a_waddr      = CIW'(p2_c_ff);
      a_wdata      = '0;

      accept   = req_valid && (state_ff == S_IDLE);
      pos_next = pos_ff + 7'd1;
      sig      = (nc == 5'd1);
      last     = (cnt_ff == nc - 5'd1);
      acc_val  = vld_ff[CIW'(p1_c_ff)] ? $signed(a_rdata) : '0;
      mac_sum  = (ACC_WIDTH+1)'(accd_ff) + (ACC_WIDTH+1)'(prod_ff);
      logit    = (ACC_WIDTH+1)'(acc_val) +
                 ((ACC_WIDTH+1)'($signed(b_rdata)) <<< FRAC_BITS);
      z        = sat_acc(logit);
      if (sig) begin
         m = zmax_ff[ACC_WIDTH-1] ? -(ACC_WIDTH+1)'(zmax_ff) : (ACC_WIDTH+1)'(zmax_ff);
      end else begin
         m = (ACC_WIDTH+1)'(zmax_ff) - (ACC_WIDTH+1)'($signed(a_rdata));
      end
      emul   = r_ff * exp_bit(step_ff[3:0]);
      r_next = q_ff[step_ff[3:0]] ? 33'((emul + 65'h0_8000_0000) >> 32) : r_ff;
      e      = sig ? r_ff : a_rdata[32:0];
      den    = sig ? SW'({1'b1, 32'd0} + 34'(r_ff)) : sum_ff;
      num    = (sig && !zneg_ff) ? {1'b1, 48'd0} : {e, 16'd0};
      nsum   = NW'(num) + NW'(den >> 1);
      trial  = {rem_ff, nlow_ff[16]};

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FEATURE_COUNT: fcount_in = csr_wdata;
            CSR_CLASS_COUNT:   ccount_in = csr_wdata[4:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_WEIGHT: begin
                     w_we = (int'(req_data.feature_index) < MAX_FEATURES) &&
                            (int'(req_data.class_index) < MAX_CLASSES);
                  end
                  KIND_BIAS: begin
                     b_we = (int'(req_data.class_index) < MAX_CLASSES);
                  end
                  KIND_FEATURE: begin
                     x_in     = req_data.value;
                     row_in   = RW'(pos_ff);
                     cnt_in   = 5'd0;
                     state_in = S_MAC;
                  end
                  default: ;
               endcase
            end
         end
         S_MAC: begin
            if (cnt_ff < nc) begin
               p1_v_in = 1'b1;
               p1_c_in = cnt_ff;
               cnt_in  = cnt_ff + 5'd1;
            end
            if (p1_v_ff) begin
               prod_in = x_ff * $signed(w_rdata);
               accd_in = acc_val;
               p2_v_in = 1'b1;
               p2_c_in = p1_c_ff;
            end
            if (p2_v_ff) begin
               a_we    = 1'b1;
               a_wdata = sat_acc(mac_sum);
               vld_in[CIW'(p2_c_ff)] = 1'b1;
            end
            if (cnt_ff >= nc && !p1_v_ff && !p2_v_ff) begin
               if (pos_next < nf) begin
                  pos_in   = pos_next;
                  state_in = S_IDLE;
               end else begin
                  pos_in   = 7'd0;
                  cnt_in   = 5'd0;
                  state_in = S_LOGIT;
               end
            end
         end
         S_LOGIT: begin
            if (cnt_ff < nc) begin
               p1_v_in = 1'b1;
               p1_c_in = cnt_ff;
               cnt_in  = cnt_ff + 5'd1;
            end
            if (p1_v_ff) begin
               a_we    = 1'b1;
               a_waddr = CIW'(p1_c_ff);
               a_wdata = z;
               if (p1_c_ff == 5'd0 || z > zmax_ff) begin
                  zmax_in = z;
               end
            end
            if (cnt_ff >= nc && !p1_v_ff) begin
               vld_in   = '0;
               sum_in   = '0;
               cnt_in   = 5'd0;
               state_in = sig ? S_EXPLD : S_EXPRD;
            end
         end
         S_EXPRD: begin
            state_in = S_EXPLD;
         end
         S_EXPLD: begin
            zneg_in = zmax_ff[ACC_WIDTH-1];
            step_in = 5'd0;
            if (m[ACC_WIDTH:FRAC_BITS+16] != '0) begin
               r_in = 33'd0;
               q_in = 16'd0;
            end else begin
               r_in = {1'b1, 32'd0};
               q_in = m[FRAC_BITS+15:FRAC_BITS];
            end
            state_in = S_EXP;
         end
         S_EXP: begin
            r_in    = r_next;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd15) begin
               if (sig) begin
                  state_in = S_DIVLD;
               end else begin
                  a_we    = 1'b1;
                  a_waddr = cidx;
                  a_wdata = ACC_WIDTH'(r_next);
                  sum_in  = sum_ff + SW'(r_next);
                  if (last) begin
                     cnt_in   = 5'd0;
                     state_in = S_DIVRD;
                  end else begin
                     cnt_in   = cnt_ff + 5'd1;
                     state_in = S_EXPRD;
                  end
               end
            end
         end
         S_DIVRD: begin
            state_in = S_DIVLD;
         end
         S_DIVLD: begin
            den_in   = den;
            rem_in   = SW'(nsum >> 17);
            nlow_in  = nsum[16:0];
            quo_in   = 17'd0;
            step_in  = 5'd0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (trial >= (SW+1)'(den_ff)) begin
               rem_in = SW'(trial - (SW+1)'(den_ff));
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = SW'(trial);
               quo_in = {quo_ff[15:0], 1'b0};
            end
            nlow_in = {nlow_ff[15:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd16) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_class   = cnt_ff[3:0];
               rsp_data_in.probability = quo_ff[16] ? 16'hFFFF : quo_ff[15:0];
               rsp_data_in.last        = last;
               if (last) begin
                  cnt_in   = 5'd0;
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 5'd1;
                  state_in = S_DIVRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= 7'd0;
         fcount_ff    <= 7'd1;
         ccount_ff    <= 5'd1;
         cnt_ff       <= 5'd0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         fcount_ff    <= fcount_in;
         ccount_ff    <= ccount_in;
         cnt_ff       <= cnt_in;
         p1_v_ff      <= p1_v_in;
         p2_v_ff      <= p2_v_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_c_ff     <= p1_c_in;
      p2_c_ff     <= p2_c_in;
      x_ff        <= x_in;
      row_ff      <= row_in;
      prod_ff     <= prod_in;
      accd_ff     <= accd_in;
      zmax_ff     <= zmax_in;
      zneg_ff     <= zneg_in;
      r_ff        <= r_in;
      q_ff        <= q_in;
      step_ff     <= step_in;
      sum_ff      <= sum_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      nlow_ff     <= nlow_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
